/* sv/i2c_atm_pkg.sv */
// ----------------------------------------------------------------------------
// I2C transaction master package
// Word types for the command and pin channels, register indexes and constants.
// ----------------------------------------------------------------------------
package i2c_atm_pkg;

	// Command word: one bus tick
	typedef struct packed {
		logic       cmd_valid;
		logic [1:0] mode;
		logic [1:0] channel;
		logic [7:0] dac_value;
		logic       sda_in;
	} in_t;

	// Pin word: bus levels and status for one tick
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
		logic       ack_error;
	} out_t;

	// Transaction modes
	localparam logic [1:0] MODE_SELECT = 2'd0;
	localparam logic [1:0] MODE_READ   = 2'd1;
	localparam logic [1:0] MODE_DAC    = 2'd2;
	localparam logic [1:0] MODE_NONE   = 2'd3;

	// Configuration register indexes
	localparam logic REG_DEV_ADDR    = 1'b0;
	localparam logic REG_ACK_TIMEOUT = 1'b1;

	// Reset values and constants
	localparam logic [6:0] DEV_ADDR_RST    = 7'd72;
	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd200;
	localparam logic [7:0] CTRL_BASE       = 8'h40;
	localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

endpackage

/* sv/i2c_adc_dac_transaction_master_top.sv */
// ----------------------------------------------------------------------------
// I2C converter transaction master
// Runs a start / address / data / stop transaction from one command word,
// advancing the bus pin state by one tick for each command word taken.
// ----------------------------------------------------------------------------
//  channel   signals                          direction  word
//  in        in_valid  in_ready  in_data      in         in_t, one bus tick
//  out       out_valid out_ready out_data     out        out_t, pins of tick
//  cfg       cfg_valid cfg_ready cfg_index    in         register write
//            cfg_data
//
// One command word per cycle while in_ready is high; each word yields one pin word
// in the following cycle. The phase state machine and the pin decode sit between
// the state registers and the output register, the single registered stage.
// in_ready drops only while the output register is full and out_ready is low.
// Reset leaves the phase idle and the pin word all zero, address 72, timeout 200.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module i2c_adc_dac_transaction_master_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  i2c_atm_pkg::in_t   in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output i2c_atm_pkg::out_t  out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data
);
	import i2c_atm_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_START_A,
		PH_START_B,
		PH_WR_LOW,
		PH_WR_HIGH,
		PH_ACK_WAIT,
		PH_ACK_END,
		PH_RD_LOW,
		PH_RD_H1,
		PH_RD_H2,
		PH_NACK_LOW,
		PH_NACK_HIGH,
		PH_STOP_A,
		PH_STOP_B,
		PH_STOP_C
	} phase_t;

	// Registers
	logic [6:0] dev_addr_q;
	logic [7:0] ack_timeout_q;
	phase_t     phase_q;
	logic [7:0] shift_q;
	logic [3:0] bit_cnt_q;
	logic [7:0] wait_cnt_q;
	logic [1:0] byte_idx_q;
	logic [1:0] mode_q;
	logic [1:0] chan_q;
	logic [7:0] dac_q;
	logic [7:0] rx_q;
	logic       err_q;
	logic       out_valid_q;
	out_t       out_q;

	// Next values
	phase_t     phase_d;
	logic [7:0] shift_d;
	logic [3:0] bit_cnt_d;
	logic [7:0] wait_cnt_d;
	logic [1:0] byte_idx_d;
	logic [1:0] mode_d;
	logic [1:0] chan_d;
	logic [7:0] dac_d;
	logic [7:0] rx_d;
	logic       err_d;
	out_t       res_d;

	logic       in_acc;
	logic       start;
	phase_t     ph;
	logic [7:0] limit;
	logic [7:0] wait_inc;
	logic [3:0] bit_inc;
	logic [1:0] idx_inc;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign limit    = (ack_timeout_q == 8'd0) ? 8'd1 : ack_timeout_q;
	assign wait_inc = wait_cnt_q + 8'd1;
	assign bit_inc  = bit_cnt_q + 4'd1;

	// Tick logic: command capture, phase step and pin decode
	always_comb begin
		start = (phase_q == PH_IDLE) && in_data.cmd_valid && (in_data.mode != MODE_NONE);
		ph         = start ? PH_START_A : phase_q;
		mode_d     = start ? in_data.mode : mode_q;
		chan_d     = start ? in_data.channel : chan_q;
		dac_d      = start ? in_data.dac_value : dac_q;
		err_d      = start ? 1'b0 : err_q;
		byte_idx_d = start ? 2'd0 : byte_idx_q;
		idx_inc    = byte_idx_d + 2'd1;

		phase_d    = ph;
		shift_d    = shift_q;
		bit_cnt_d  = bit_cnt_q;
		wait_cnt_d = wait_cnt_q;
		rx_d       = rx_q;

		res_d           = '0;
		res_d.busy_res  = 1'b1;

		case (ph)
			PH_START_A: begin
				res_d.scl_level = 1'b1;
				res_d.sda_drive = 1'b1;
				phase_d = PH_START_B;
			end
			PH_START_B: begin
				res_d.sda_drive = 1'b1;
				shift_d   = {dev_addr_q, mode_d == MODE_READ};
				bit_cnt_d = 4'd0;
				phase_d   = PH_WR_LOW;
			end
			PH_WR_LOW: begin
				res_d.sda_level = shift_q[7];
				res_d.sda_drive = 1'b1;
				phase_d = PH_WR_HIGH;
			end
			PH_WR_HIGH: begin
				res_d.scl_level = 1'b1;
				res_d.sda_level = shift_q[7];
				res_d.sda_drive = 1'b1;
				shift_d   = {shift_q[6:0], 1'b0};
				bit_cnt_d = bit_inc;
				if (bit_inc >= BITS_PER_BYTE) begin
					wait_cnt_d = 8'd0;
					phase_d    = PH_ACK_WAIT;
				end else begin
					phase_d = PH_WR_LOW;
				end
			end
			PH_ACK_WAIT: begin
				// slave pulls SDA low to acknowledge
				res_d.scl_level = 1'b1;
				if (!in_data.sda_in) begin
					phase_d = PH_ACK_END;
				end else begin
					wait_cnt_d = wait_inc;
					if (wait_inc == 8'd0 || wait_inc >= limit) begin
						err_d   = 1'b1;
						phase_d = PH_ACK_END;
					end
				end
			end
			PH_ACK_END: begin
				byte_idx_d = idx_inc;
				if (mode_d == MODE_READ) begin
					rx_d      = 8'd0;
					bit_cnt_d = 4'd0;
					phase_d   = PH_RD_LOW;
				end else if (idx_inc == 2'd1) begin
					shift_d   = (mode_d == MODE_SELECT) ? (CTRL_BASE | {6'd0, chan_d})
						: CTRL_BASE;
					bit_cnt_d = 4'd0;
					phase_d   = PH_WR_LOW;
				end else if (idx_inc == 2'd2 && mode_d == MODE_DAC) begin
					shift_d   = dac_d;
					bit_cnt_d = 4'd0;
					phase_d   = PH_WR_LOW;
				end else begin
					phase_d = PH_STOP_A;
				end
			end
			PH_RD_LOW: begin
				phase_d = PH_RD_H1;
			end
			PH_RD_H1: begin
				res_d.scl_level = 1'b1;
				phase_d = PH_RD_H2;
			end
			PH_RD_H2: begin
				// sample on the second high tick
				res_d.scl_level = 1'b1;
				rx_d      = {rx_q[6:0], in_data.sda_in};
				bit_cnt_d = bit_inc;
				phase_d   = (bit_inc >= BITS_PER_BYTE) ? PH_NACK_LOW : PH_RD_LOW;
			end
			PH_NACK_LOW: begin
				res_d.sda_level = 1'b1;
				res_d.sda_drive = 1'b1;
				phase_d = PH_NACK_HIGH;
			end
			PH_NACK_HIGH: begin
				res_d.scl_level = 1'b1;
				res_d.sda_level = 1'b1;
				res_d.sda_drive = 1'b1;
				phase_d = PH_STOP_A;
			end
			PH_STOP_A: begin
				res_d.sda_drive = 1'b1;
				phase_d = PH_STOP_B;
			end
			PH_STOP_B: begin
				res_d.scl_level = 1'b1;
				res_d.sda_drive = 1'b1;
				phase_d = PH_STOP_C;
			end
			PH_STOP_C: begin
				res_d.scl_level = 1'b1;
				res_d.sda_level = 1'b1;
				res_d.sda_drive = 1'b1;
				res_d.busy_res  = 1'b0;
				res_d.done_res  = 1'b1;
				res_d.read_byte = (mode_d == MODE_READ) ? rx_q : 8'd0;
				phase_d = PH_IDLE;
			end
			default: begin
				// idle bus
				res_d.scl_level = 1'b1;
				res_d.sda_level = 1'b1;
				res_d.sda_drive = 1'b1;
				res_d.busy_res  = 1'b0;
				phase_d = PH_IDLE;
			end
		endcase

		res_d.ack_error = err_d;
	end

	// State, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q    <= DEV_ADDR_RST;
			ack_timeout_q <= ACK_TIMEOUT_RST;
			phase_q       <= PH_IDLE;
			shift_q       <= '0;
			bit_cnt_q     <= '0;
			wait_cnt_q    <= '0;
			byte_idx_q    <= '0;
			mode_q        <= '0;
			chan_q        <= '0;
			dac_q         <= '0;
			rx_q          <= '0;
			err_q         <= 1'b0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_DEV_ADDR:    dev_addr_q    <= cfg_data[6:0];
					REG_ACK_TIMEOUT: ack_timeout_q <= cfg_data;
					default:         ;
				endcase
			end
			if (in_acc) begin
				phase_q     <= phase_d;
				shift_q     <= shift_d;
				bit_cnt_q   <= bit_cnt_d;
				wait_cnt_q  <= wait_cnt_d;
				byte_idx_q  <= byte_idx_d;
				mode_q      <= mode_d;
				chan_q      <= chan_d;
				dac_q       <= dac_d;
				rx_q        <= rx_d;
				err_q       <= err_d;
				out_q       <= res_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
